// File: hdl/tsa_pkg.sv
// Shared types and constants for the timestamp stream audit block.
`timescale 1ns / 1ps
package tsa_pkg;

   localparam int unsigned SEC_W   = 32;
   localparam int unsigned NANOS_W = 30;
   localparam int unsigned NS_W    = 62;
   localparam int unsigned CNT_W   = 32;

   localparam logic [NANOS_W-1:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 232;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      logic            rcv_zero;
      logic            cap_zero;
      logic [NS_W-1:0] rcv_ns;
      logic [NS_W-1:0] cap_ns;
   } tsa_item_type;

   // Result fields, last field in the lowest bits.
   typedef struct packed {
      logic [NS_W-1:0]  last_capture_time;
      logic [NS_W-1:0]  first_capture_time;
      logic             mixed_population;
      logic [CNT_W-1:0] receive_zero_after_count;
      logic [CNT_W-1:0] capture_zero_after_count;
      logic             receive_ever_nonzero;
      logic             capture_ever_nonzero;
      logic             receive_monotonic;
      logic             capture_strictly_increasing;
      logic             capture_monotonic;
      logic [CNT_W-1:0] message_count;
   } tsa_result_type;

   localparam int unsigned RSP_PAD_W = RSP_DATA_W - $bits(tsa_result_type);

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// File: hdl/tsa_front.sv
// Front stage: takes requests, multiplies seconds to nanoseconds and classifies zero stamps.
`timescale 1ns / 1ps
module tsa_front import tsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SEC_W-1:0]    capture_seconds,
   input  logic [NANOS_W-1:0]  capture_nanos,
   input  logic [SEC_W-1:0]    receive_seconds,
   input  logic [NANOS_W-1:0]  receive_nanos,
   output logic                out_valid,
   input  logic                out_ready,
   output tsa_item_type        out_item
);

   logic                s1_valid_ff, s1_valid_in;
   logic [NS_W-1:0]     cap_prod_ff, cap_prod_in;
   logic [NS_W-1:0]     rcv_prod_ff, rcv_prod_in;
   logic [NANOS_W-1:0]  cap_nanos_ff;
   logic [NANOS_W-1:0]  rcv_nanos_ff;
   logic                cap_zero_ff, cap_zero_in;
   logic                rcv_zero_ff, rcv_zero_in;
   logic                take;

   assign in_ready = !s1_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign cap_prod_in = {30'd0, capture_seconds} * {32'd0, NS_PER_SEC};
   assign rcv_prod_in = {30'd0, receive_seconds} * {32'd0, NS_PER_SEC};
   assign cap_zero_in = (capture_seconds == '0) && (capture_nanos == '0);
   assign rcv_zero_in = (receive_seconds == '0) && (receive_nanos == '0);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cap_prod_ff  <= cap_prod_in;
         rcv_prod_ff  <= rcv_prod_in;
         cap_nanos_ff <= capture_nanos;
         rcv_nanos_ff <= receive_nanos;
         cap_zero_ff  <= cap_zero_in;
         rcv_zero_ff  <= rcv_zero_in;
      end
   end

   // The sum cannot overflow 62 bits even with out-of-range nanoseconds.
   assign out_valid       = s1_valid_ff;
   assign out_item.cap_ns = cap_prod_ff + {32'd0, cap_nanos_ff};
   assign out_item.rcv_ns = rcv_prod_ff + {32'd0, rcv_nanos_ff};
   assign out_item.cap_zero = cap_zero_ff;
   assign out_item.rcv_zero = rcv_zero_ff;

endmodule

// File: hdl/tsa_queue.sv
// Short queue of classified requests between the front and the back.
`timescale 1ns / 1ps
module tsa_queue import tsa_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tsa_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output tsa_item_type  out_item
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   tsa_item_type   mem [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: hdl/tsa_back.sv
// Back stage: updates the running audit state and holds the result register.
`timescale 1ns / 1ps
module tsa_back import tsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  tsa_item_type    in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output tsa_result_type  out_result
);

   logic              out_valid_ff, out_valid_in;
   tsa_result_type    result_ff, result_in;
   logic [CNT_W-1:0]  msg_cnt_ff, msg_cnt_in;
   logic              cap_mono_ff, cap_mono_in;
   logic              cap_strict_ff, cap_strict_in;
   logic              rcv_mono_ff, rcv_mono_in;
   logic              cap_nz_ff, cap_nz_in;
   logic              rcv_nz_ff, rcv_nz_in;
   logic [CNT_W-1:0]  cap_late_ff, cap_late_in;
   logic [CNT_W-1:0]  rcv_late_ff, rcv_late_in;
   logic [NS_W-1:0]   first_cap_ff, first_cap_in;
   logic [NS_W-1:0]   prev_cap_ff;
   logic [NS_W-1:0]   prev_rcv_ff;
   logic              take, seen;

   assign in_ready   = !out_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign seen       = (msg_cnt_ff != '0);
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   always_comb begin
      msg_cnt_in    = sat_inc(msg_cnt_ff);
      cap_mono_in   = cap_mono_ff;
      cap_strict_in = cap_strict_ff;
      rcv_mono_in   = rcv_mono_ff;
      cap_nz_in     = cap_nz_ff || !in_item.cap_zero;
      rcv_nz_in     = rcv_nz_ff || !in_item.rcv_zero;
      cap_late_in   = cap_late_ff;
      rcv_late_in   = rcv_late_ff;
      first_cap_in  = first_cap_ff;

      if (in_item.cap_zero && cap_nz_ff) begin
         cap_late_in = sat_inc(cap_late_ff);
      end
      if (in_item.rcv_zero && rcv_nz_ff) begin
         rcv_late_in = sat_inc(rcv_late_ff);
      end

      // For ordering, the first request only records its capture time; it is never out of order.
      if (seen) begin
         if (in_item.cap_ns < prev_cap_ff) begin
            cap_mono_in = 1'b0;
         end
         if (in_item.cap_ns <= prev_cap_ff) begin
            cap_strict_in = 1'b0;
         end
         if (in_item.rcv_ns < prev_rcv_ff) begin
            rcv_mono_in = 1'b0;
         end
      end else begin
         first_cap_in = in_item.cap_ns;
      end

      result_in.message_count               = msg_cnt_in;
      result_in.capture_monotonic           = cap_mono_in;
      result_in.capture_strictly_increasing = cap_strict_in;
      result_in.receive_monotonic           = rcv_mono_in;
      result_in.capture_ever_nonzero        = cap_nz_in;
      result_in.receive_ever_nonzero        = rcv_nz_in;
      result_in.capture_zero_after_count    = cap_late_in;
      result_in.receive_zero_after_count    = rcv_late_in;
      result_in.mixed_population            = (cap_late_in != '0) || (rcv_late_in != '0);
      result_in.first_capture_time          = first_cap_in;
      result_in.last_capture_time           = in_item.cap_ns;

      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         msg_cnt_ff    <= '0;
         cap_mono_ff   <= 1'b1;
         cap_strict_ff <= 1'b1;
         rcv_mono_ff   <= 1'b1;
         cap_nz_ff     <= 1'b0;
         rcv_nz_ff     <= 1'b0;
         cap_late_ff   <= '0;
         rcv_late_ff   <= '0;
         first_cap_ff  <= '0;
         prev_cap_ff   <= '0;
         prev_rcv_ff   <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            msg_cnt_ff    <= msg_cnt_in;
            cap_mono_ff   <= cap_mono_in;
            cap_strict_ff <= cap_strict_in;
            rcv_mono_ff   <= rcv_mono_in;
            cap_nz_ff     <= cap_nz_in;
            rcv_nz_ff     <= rcv_nz_in;
            cap_late_ff   <= cap_late_in;
            rcv_late_ff   <= rcv_late_in;
            first_cap_ff  <= first_cap_in;
            prev_cap_ff   <= in_item.cap_ns;
            prev_rcv_ff   <= in_item.rcv_ns;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

// File: hdl/timestamp_stream_audit.sv
// A request passes the front register, then the queue write, then the result register;
// its result is valid once the result register has loaded, when the result side is not stalled.
// Throughput: one request per cycle while the queue has room; the two 32 by 30 bit constant
// multiplies sit in the front stage and the 62-bit compares in the back stage.
// Reset is synchronous and active high; it empties the queue and restores all audit state.
`timescale 1ns / 1ps
module timestamp_stream_audit import tsa_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // capture_seconds[31:0], capture_nanos[61:32], receive_seconds[93:62],
   // receive_nanos[123:94], zero fill[127:124]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // message_count[31:0], capture_monotonic[32], capture_strictly_increasing[33],
   // receive_monotonic[34], capture_ever_nonzero[35], receive_ever_nonzero[36],
   // capture_zero_after_count[68:37], receive_zero_after_count[100:69],
   // mixed_population[101], first_capture_time[163:102], last_capture_time[225:164],
   // zero fill[231:226]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic            front_valid, front_ready;
   tsa_item_type    front_item;
   logic            queue_valid, queue_ready;
   tsa_item_type    queue_item;
   tsa_result_type  result;

   tsa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .capture_seconds (req_tdata[31:0]),
      .capture_nanos   (req_tdata[61:32]),
      .receive_seconds (req_tdata[93:62]),
      .receive_nanos   (req_tdata[123:94]),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_item        (front_item)
   );

   tsa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   tsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, result};

endmodule

// File: hdl/tsa_checker.sv
// Port-level checks for the timestamp stream audit block and their binding.
`timescale 1ns / 1ps
module tsa_checker import tsa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response counts at least the request that caused it.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] != '0)
      else $error("response with zero message count");

   // A strictly increasing capture stream is also monotonic.
   a_strict_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[32])
      else $error("strict flag set without monotonic flag");

   // The mixed flag follows the two zero-after counters.
   a_mixed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[101] == ((rsp_tdata[68:37] != '0) || (rsp_tdata[100:69] != '0)))
      else $error("mixed population flag disagrees with counters");

   // A late capture zero can only be counted after a nonzero capture stamp was seen.
   a_late_needs_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[68:37] != '0) |-> rsp_tdata[35])
      else $error("zero-after count without a nonzero capture stamp");

endmodule

bind timestamp_stream_audit tsa_checker u_tsa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
